// ----- design/pswrl_pkg.sv -----
// Package for the per-source window rate limiter.
// Holds table geometry, register indexes, hit reasons and shared types.
// No dependencies.
package pswrl_pkg;

    localparam int unsigned TableEntries = 4096;
    localparam int unsigned IdxW = $clog2(TableEntries);
    localparam int unsigned CntrW = (TableEntries > 1) ? IdxW + 1 : 1;
    localparam logic [63:0] WindowNs = 64'd1000000000;

    localparam logic [2:0] CfgPps = 3'd0;
    localparam logic [2:0] CfgSynPps = 3'd1;
    localparam logic [2:0] CfgUdpPps = 3'd2;
    localparam logic [2:0] CfgUdpByte = 3'd3;
    localparam logic [2:0] CfgByte = 3'd4;
    localparam logic [2:0] CfgDrop = 3'd5;

    localparam logic [2:0] ReasonNone = 3'd0;
    localparam logic [2:0] ReasonPps = 3'd1;
    localparam logic [2:0] ReasonSyn = 3'd2;
    localparam logic [2:0] ReasonUdpPps = 3'd3;
    localparam logic [2:0] ReasonUdpByte = 3'd4;
    localparam logic [2:0] ReasonByte = 3'd5;

    typedef struct packed {
        logic [31:0] source_addr;
        logic [63:0] now_ns;
        logic        syn_flag;
        logic        udp_flag;
        logic [15:0] packet_len;
    } t_pkt;

    typedef struct packed {
        logic [31:0] pps;
        logic [31:0] syn_pps;
        logic [31:0] udp_pps;
        logic [63:0] udp_byte;
        logic [63:0] byte_lim;
        logic        drop_on_hit;
    } t_cfg;

    typedef struct packed {
        logic [31:0] addr;
        logic [63:0] win;
        logic [31:0] pkt;
        logic [31:0] syn;
        logic [31:0] udp_pkt;
        logic [63:0] udp_byte;
        logic [63:0] byte_cnt;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE
    } t_state;

endpackage

// ----- design/pswrl_front.sv -----
// Front end: accepts packet items and holds them in a two-entry queue.
// Depends on pswrl_pkg.
module pswrl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pswrl_pkg::t_pkt   i_pkt,
    output logic              o_valid,
    input  logic              i_ready,
    output pswrl_pkg::t_pkt   o_pkt
);

    pswrl_pkg::t_pkt r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pkt   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_pkt;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overflow");
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1) else $error("push lost");
`endif

endmodule

// ----- design/pswrl_back.sv -----
// Back end: table read, limit decision and counter write-back.
// Depends on pswrl_pkg.
module pswrl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pswrl_pkg::t_pkt   i_pkt,
    input  pswrl_pkg::t_cfg   i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_drop,
    output logic [2:0]        o_reason
);

    pswrl_pkg::t_entry mem [pswrl_pkg::TableEntries];
    logic              vld [pswrl_pkg::TableEntries];

    pswrl_pkg::t_state r_st, n_st;
    logic [pswrl_pkg::CntrW-1:0] r_clr;
    pswrl_pkg::t_pkt   r_pkt;
    pswrl_pkg::t_entry r_ent;
    logic              r_ev;
    logic              r_ov, r_drop;
    logic [2:0]        r_reason;

    logic [pswrl_pkg::IdxW-1:0] idx, cidx;
    logic              fresh;
    logic [63:0]       elapsed;
    logic [2:0]        reason;
    logic              take, wr_en, wr_vld;
    logic [pswrl_pkg::IdxW-1:0] wr_idx;
    pswrl_pkg::t_entry wr_ent;

    assign idx  = i_pkt.source_addr[pswrl_pkg::IdxW-1:0];
    assign cidx = r_pkt.source_addr[pswrl_pkg::IdxW-1:0];
    assign elapsed = r_pkt.now_ns - r_ent.win;
    assign fresh = !r_ev || (r_ent.addr != r_pkt.source_addr)
                   || (elapsed >= pswrl_pkg::WindowNs);

    always_comb begin
        reason = pswrl_pkg::ReasonNone;
        if (i_cfg.pps != 32'd0 && r_ent.pkt >= i_cfg.pps)
            reason = pswrl_pkg::ReasonPps;
        else if (r_pkt.syn_flag && i_cfg.syn_pps != 32'd0 && r_ent.syn >= i_cfg.syn_pps)
            reason = pswrl_pkg::ReasonSyn;
        else if (r_pkt.udp_flag && i_cfg.udp_pps != 32'd0 && r_ent.udp_pkt >= i_cfg.udp_pps)
            reason = pswrl_pkg::ReasonUdpPps;
        else if (r_pkt.udp_flag && i_cfg.udp_byte != 64'd0
                 && r_ent.udp_byte >= i_cfg.udp_byte)
            reason = pswrl_pkg::ReasonUdpByte;
        else if (i_cfg.byte_lim != 64'd0 && r_ent.byte_cnt >= i_cfg.byte_lim)
            reason = pswrl_pkg::ReasonByte;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pswrl_pkg::ST_CLEAR:
                if (r_clr == pswrl_pkg::CntrW'(pswrl_pkg::TableEntries - 1))
                    n_st = pswrl_pkg::ST_IDLE;
            pswrl_pkg::ST_IDLE:   if (take) n_st = pswrl_pkg::ST_READ;
            pswrl_pkg::ST_READ:   n_st = pswrl_pkg::ST_DECIDE;
            pswrl_pkg::ST_DECIDE: n_st = pswrl_pkg::ST_IDLE;
            default:              n_st = pswrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        take   = 1'b0;
        wr_en  = 1'b0;
        wr_vld = 1'b1;
        wr_idx = cidx;
        wr_ent = r_ent;
        unique case (r_st)
            pswrl_pkg::ST_CLEAR: begin
                wr_en  = 1'b1;
                wr_vld = 1'b0;
                wr_idx = r_clr[pswrl_pkg::IdxW-1:0];
            end
            pswrl_pkg::ST_IDLE: take = i_valid && (!r_ov || i_ready);
            pswrl_pkg::ST_READ: ;
            pswrl_pkg::ST_DECIDE: begin
                if (fresh) begin
                    wr_en = 1'b1;
                    wr_ent.addr     = r_pkt.source_addr;
                    wr_ent.win      = r_pkt.now_ns;
                    wr_ent.pkt      = 32'd1;
                    wr_ent.syn      = {31'd0, r_pkt.syn_flag};
                    wr_ent.udp_pkt  = {31'd0, r_pkt.udp_flag};
                    wr_ent.udp_byte = r_pkt.udp_flag ? {48'd0, r_pkt.packet_len} : 64'd0;
                    wr_ent.byte_cnt = {48'd0, r_pkt.packet_len};
                end else if (reason == pswrl_pkg::ReasonNone) begin
                    wr_en = 1'b1;
                    wr_ent.pkt = r_ent.pkt + 32'd1;
                    if (r_pkt.syn_flag) wr_ent.syn = r_ent.syn + 32'd1;
                    if (r_pkt.udp_flag) begin
                        wr_ent.udp_pkt  = r_ent.udp_pkt + 32'd1;
                        wr_ent.udp_byte = r_ent.udp_byte + {48'd0, r_pkt.packet_len};
                    end
                    wr_ent.byte_cnt = r_ent.byte_cnt + {48'd0, r_pkt.packet_len};
                end
            end
            default: ;
        endcase
    end

    assign o_ready  = take;
    assign o_valid  = r_ov;
    assign o_drop   = r_drop;
    assign o_reason = r_reason;

    always_ff @(posedge i_clk) begin
        if (wr_en && r_st != pswrl_pkg::ST_CLEAR) mem[wr_idx] <= wr_ent;
        if (wr_en) vld[wr_idx] <= wr_vld;
        if (take) r_pkt <= i_pkt;
        if (take) begin
            r_ent <= mem[idx];
            r_ev  <= vld[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= pswrl_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ov     <= 1'b0;
            r_drop   <= 1'b0;
            r_reason <= pswrl_pkg::ReasonNone;
        end else begin
            r_st <= n_st;
            if (r_st == pswrl_pkg::ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (r_st == pswrl_pkg::ST_DECIDE) begin
                r_ov     <= 1'b1;
                r_drop   <= !fresh && reason != pswrl_pkg::ReasonNone && i_cfg.drop_on_hit;
                r_reason <= fresh ? pswrl_pkg::ReasonNone : reason;
            end
        end
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_st == pswrl_pkg::ST_READ) else $error("take outside idle");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == pswrl_pkg::ST_DECIDE |=> r_ov) else $error("result lost");
    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |-> !take) else $error("accepted over pending result");
    a_fresh_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == pswrl_pkg::ST_DECIDE && fresh |=>
        !r_drop && r_reason == pswrl_pkg::ReasonNone)
        else $error("fresh window reported a hit");
`endif

endmodule

// ----- design/per_source_window_rate_limiter.sv -----
// Top level of the per-source window rate limiter.
// Depends on pswrl_pkg, pswrl_front, pswrl_back.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: source_addr, now_ns, packet_len; tuser: syn_flag, udp_flag
//  m_axis   | out       | tdata: drop, hit_reason
//  cfg      | in        | index 3 bits, data 64 bits
//
// Packets are handled one at a time: queue pop with table read, registered read data, decide
// and write back. After reset a clearing pass runs over every table entry; the back end
// takes no packet then (the queue still fills), configuration writes are. A two-entry queue
// takes packets while the back end works; a pending result holds the back end until taken.
module per_source_window_rate_limiter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // source_addr[31:0], now_ns[95:32], packet_len[111:96]
    input  logic [1:0]   s_axis_tuser,  // syn_flag[0], udp_flag[1]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // drop[0], hit_reason[3:1]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    pswrl_pkg::t_pkt in_pkt, q_pkt;
    pswrl_pkg::t_cfg r_cfg;
    logic            q_valid, q_ready, drop;
    logic [2:0]      reason;

    assign in_pkt = {s_axis_tdata[31:0], s_axis_tdata[95:32], s_axis_tuser[0],
                     s_axis_tuser[1], s_axis_tdata[111:96]};
    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {4'd0, reason, drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pswrl_pkg::CfgPps:     r_cfg.pps         <= i_cfg_data[31:0];
                pswrl_pkg::CfgSynPps:  r_cfg.syn_pps     <= i_cfg_data[31:0];
                pswrl_pkg::CfgUdpPps:  r_cfg.udp_pps     <= i_cfg_data[31:0];
                pswrl_pkg::CfgUdpByte: r_cfg.udp_byte    <= i_cfg_data;
                pswrl_pkg::CfgByte:    r_cfg.byte_lim    <= i_cfg_data;
                pswrl_pkg::CfgDrop:    r_cfg.drop_on_hit <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pswrl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pkt   (in_pkt),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_pkt   (q_pkt)
    );

    pswrl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_pkt    (q_pkt),
        .i_cfg    (r_cfg),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_drop   (drop),
        .o_reason (reason)
    );

endmodule
